// File: sv/wsrs_pkg.sv
// Package: shared types and constants for the window square-root ratio scaler.
`timescale 1ns / 1ps
package wsrs_pkg;

    localparam int SAMPLE_W = 32;
    localparam int RATIO_W  = 32;
    localparam int ROOT_W   = 24;
    localparam int SCALE_W  = 24;

    // Commands from controller to datapath
    typedef struct packed {
        logic store;      // write input sample into ring
        logic load_pair;  // register older/newer read data
        logic div_start;  // start serial divide
        logic sqrt_start; // start serial square root
        logic acc_clear;  // clear accumulator and flag
        logic acc_add;    // add root to accumulator
        logic mean_start; // start mean divide
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic mean_done;
    } t_status;

endpackage

// File: sv/wsrs_if.sv
// Interfaces: valid/ready channels for samples and results.
`timescale 1ns / 1ps
interface wsrs_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wsrs_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] scale_estimate;
    logic        window_full;
    logic        zero_divisor;
    modport source (output valid, output scale_estimate, output window_full,
                    output zero_divisor, input ready);
    modport sink   (input valid, input scale_estimate, input window_full,
                    input zero_divisor, output ready);
endinterface

// File: sv/wsrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wsrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 5
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/wsrs_datapath.sv
// Datapath: sample ring, serial divider, serial square root, accumulator, mean.
`timescale 1ns / 1ps
module wsrs_datapath #(
    parameter int INTERVALS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wsrs_pkg::t_cmd            i_cmd,
    input  logic [31:0]               i_sample,
    input  logic [$clog2(INTERVALS+1)-1:0] i_waddr,
    input  logic [$clog2(INTERVALS+1)-1:0] i_raddr,
    input  logic                      i_rd_older,
    output wsrs_pkg::t_status         o_status,
    output logic [23:0]               o_mean,
    output logic                      o_zero
);
    import wsrs_pkg::*;

    localparam int DEPTH = INTERVALS + 1;
    localparam int SUM_W = ROOT_W + $clog2(INTERVALS + 1);
    localparam int CW    = 7;

    logic [31:0] w_rdata;

    wsrs_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.store),
        .i_waddr(i_waddr),
        .i_wdata(i_sample),
        .i_raddr(i_raddr),
        .o_rdata(w_rdata)
    );

    // Operand capture
    logic [31:0] r_older, r_newer;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pair) begin
            if (i_rd_older) r_older <= w_rdata;
            else            r_newer <= w_rdata;
        end
    end

    // Restoring divide of newer<<16 by older, one quotient bit per cycle (48 bits)
    logic [47:0] r_dq;   // dividend shifting into quotient
    logic [32:0] r_drem;
    logic [CW-1:0] r_dcnt;
    logic        r_dbusy, r_ddone;
    logic [32:0] w_dtrial;
    logic [33:0] w_dsh;
    assign w_dsh    = {r_drem, r_dq[47]};
    assign w_dtrial = w_dsh[32:0] - {1'b0, r_older};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.div_start) begin
                r_dq    <= {r_newer, 16'h0000};
                r_drem  <= '0;
                r_dcnt  <= CW'(48);
                r_dbusy <= 1'b1;
            end else if (r_dbusy) begin
                if (w_dsh >= {2'b00, r_older}) begin
                    r_drem <= w_dtrial;
                    r_dq   <= {r_dq[46:0], 1'b1};
                end else begin
                    r_drem <= w_dsh[32:0];
                    r_dq   <= {r_dq[46:0], 1'b0};
                end
                r_dcnt <= r_dcnt - CW'(1);
                if (r_dcnt == CW'(1)) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
        end
    end

    // Saturated Q16.16 ratio
    logic [31:0] w_ratio;
    assign w_ratio = (r_older == 32'd0 || r_dq[47:32] != 16'd0) ? 32'hFFFF_FFFF
                                                                : r_dq[31:0];

    // Square root of ratio<<16 (48 bits), two radicand bits per cycle
    logic [47:0] r_sv;
    logic [25:0] r_srem;
    logic [23:0] r_sroot;
    logic [4:0]  r_scnt;
    logic        r_sbusy, r_sdone;
    logic [25:0] w_srem_sh, w_strial;
    assign w_srem_sh = {r_srem[23:0], r_sv[47:46]};
    assign w_strial  = {r_sroot, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbusy <= 1'b0;
            r_sdone <= 1'b0;
        end else begin
            r_sdone <= 1'b0;
            if (i_cmd.sqrt_start) begin
                r_sv    <= {w_ratio, 16'h0000};
                r_srem  <= '0;
                r_sroot <= '0;
                r_scnt  <= 5'd24;
                r_sbusy <= 1'b1;
            end else if (r_sbusy) begin
                r_sv <= {r_sv[45:0], 2'b00};
                if (w_srem_sh >= w_strial) begin
                    r_srem  <= w_srem_sh - w_strial;
                    r_sroot <= {r_sroot[22:0], 1'b1};
                end else begin
                    r_srem  <= w_srem_sh;
                    r_sroot <= {r_sroot[22:0], 1'b0};
                end
                r_scnt <= r_scnt - 5'd1;
                if (r_scnt == 5'd1) begin
                    r_sbusy <= 1'b0;
                    r_sdone <= 1'b1;
                end
            end
        end
    end

    // Accumulate roots and zero-divisor flag
    logic [SUM_W-1:0] r_sum;
    logic             r_zero;
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clear) begin
            r_sum  <= '0;
            r_zero <= 1'b0;
        end else if (i_cmd.acc_add) begin
            r_sum  <= r_sum + SUM_W'(r_sroot);
            r_zero <= r_zero | (r_older == 32'd0);
        end
    end

    // Mean: multiply the sum by a rounded-up reciprocal of INTERVALS, exact for any sum
    localparam int          MK   = SUM_W + $clog2(INTERVALS);
    localparam logic [63:0] MREC = ((64'd1 << MK) + 64'(INTERVALS) - 64'd1) / 64'(INTERVALS);
    localparam int          PW   = 2 * SUM_W + 1;

    logic [SUM_W:0]   w_mrec;
    logic [PW-1:0]    w_mprod;
    logic [23:0]      r_mq;
    logic             r_mpend, r_mdone;
    assign w_mrec  = MREC[SUM_W:0];
    assign w_mprod = {{(SUM_W+1){1'b0}}, r_sum} * {{SUM_W{1'b0}}, w_mrec};

    // Register mean_start so the last root has landed in the sum, then take the mean
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpend <= 1'b0;
            r_mdone <= 1'b0;
        end else begin
            r_mdone <= 1'b0;
            r_mpend <= i_cmd.mean_start;
            if (r_mpend) begin
                r_mq    <= w_mprod[MK +: SCALE_W];
                r_mdone <= 1'b1;
            end
        end
    end

    assign o_mean = r_mq;
    assign o_zero = r_zero;
    assign o_status.div_done  = r_ddone;
    assign o_status.sqrt_done = r_sdone;
    assign o_status.mean_done = r_mdone;
endmodule

// File: sv/wsrs_ctrl.sv
// Controller: ring pointers, fill count and sequencing of the per-item pass.
`timescale 1ns / 1ps
module wsrs_ctrl #(
    parameter int INTERVALS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_full,
    input  wsrs_pkg::t_status         i_status,
    output wsrs_pkg::t_cmd            o_cmd,
    output logic [$clog2(INTERVALS+1)-1:0] o_waddr,
    output logic [$clog2(INTERVALS+1)-1:0] o_raddr,
    output logic                      o_rd_older
);
    import wsrs_pkg::*;

    localparam int DEPTH = INTERVALS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(INTERVALS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDO   = 4'd1;
    localparam logic [3:0] S_RDN   = 4'd2;
    localparam logic [3:0] S_CAPO  = 4'd3;
    localparam logic [3:0] S_CAPN  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_ADD   = 4'd7;
    localparam logic [3:0] S_MEAN  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_wptr, n_wptr, r_optr, n_optr, r_older, n_older;
    logic [FW-1:0] r_fill, n_fill;
    logic [IW-1:0] r_cnt, n_cnt;
    logic          r_full, n_full;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // Next-state and command logic
    always_comb begin
        n_state = r_state;
        n_wptr  = r_wptr;
        n_optr  = r_optr;
        n_older = r_older;
        n_fill  = r_fill;
        n_cnt   = r_cnt;
        n_full  = r_full;
        o_cmd   = '0;
        o_raddr = r_older;
        o_rd_older = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    n_wptr = inc(r_wptr);
                    if (r_fill == FW'(DEPTH)) begin
                        n_optr = inc(r_optr);
                    end else begin
                        n_fill = r_fill + FW'(1);
                    end
                    o_cmd.acc_clear = 1'b1;
                    if (r_fill >= FW'(DEPTH - 1)) begin
                        n_full  = 1'b1;
                        n_older = (r_fill == FW'(DEPTH)) ? inc(r_optr) : r_optr;
                        n_cnt   = IW'(INTERVALS);
                        n_state = S_RDO;
                    end else begin
                        n_full  = 1'b0;
                        n_state = S_OUT;
                    end
                end
            end
            S_RDO: begin
                o_raddr = r_older;
                n_state = S_RDN;
            end
            S_RDN: begin
                o_raddr = inc(r_older);
                o_cmd.load_pair = 1'b1;
                o_rd_older = 1'b1;
                n_state = S_CAPN;
            end
            S_CAPN: begin
                o_cmd.load_pair = 1'b1;
                o_rd_older = 1'b0;
                n_state = S_CAPO;
            end
            S_CAPO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (i_status.sqrt_done) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.acc_add = 1'b1;
                n_older = inc(r_older);
                n_cnt   = r_cnt - IW'(1);
                if (r_cnt == IW'(1)) begin
                    n_state = S_MEAN;
                    o_cmd.mean_start = 1'b1;
                end else begin
                    n_state = S_RDO;
                end
            end
            S_MEAN: begin
                if (i_status.mean_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wptr  <= '0;
            r_optr  <= '0;
            r_older <= '0;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_full  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wptr  <= n_wptr;
            r_optr  <= n_optr;
            r_older <= n_older;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            r_full  <= n_full;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_full      = r_full;
    assign o_waddr     = r_wptr;
endmodule

// File: sv/window_sqrt_ratio_scale.sv
// Top level: window square-root ratio scaler.
// Each sample item is written into a ring of INTERVALS+1 entries; once the ring
// is full the result is the mean of sqrt(newer/older) over the INTERVALS
// consecutive pairs, unsigned Q8.16, with zero_divisor set if any older sample
// was zero. Before the ring is full the result is zero with window_full low.
// For a full-ring item, each pair reads the ring, runs the 48-bit bit-serial
// divide and the square root and accumulates the root; then the mean is taken
// by reciprocal multiply, with the accept and result states around the pass.
// One item is in work at a time.
`timescale 1ns / 1ps
module window_sqrt_ratio_scale #(
    parameter int INTERVALS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wsrs_in_if.sink         i_in,
    wsrs_out_if.source      o_out
);
    import wsrs_pkg::*;

    localparam int AW = $clog2(INTERVALS + 1);

    t_cmd          w_cmd;
    t_status       w_status;
    logic [AW-1:0] w_waddr, w_raddr;
    logic          w_rd_older, w_full, w_zero;
    logic [23:0]   w_mean;

    wsrs_ctrl #(.INTERVALS(INTERVALS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .o_full     (w_full),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_waddr    (w_waddr),
        .o_raddr    (w_raddr),
        .o_rd_older (w_rd_older)
    );

    wsrs_datapath #(.INTERVALS(INTERVALS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_sample  (i_in.sample),
        .i_waddr   (w_waddr),
        .i_raddr   (w_raddr),
        .i_rd_older(w_rd_older),
        .o_status  (w_status),
        .o_mean    (w_mean),
        .o_zero    (w_zero)
    );

    // Zero result until the ring is full
    assign o_out.scale_estimate = w_full ? w_mean : 24'd0;
    assign o_out.window_full    = w_full;
    assign o_out.zero_divisor   = w_full & w_zero;
endmodule
